@@ hw/rtl/p3kf_pkg.sv @@
// Package for the 3x3 pixel kernel filter.
// Holds register indexes, filter mode codes, reset values and the stage control struct.
// No dependencies.
`default_nettype none

package p3kf_pkg;

  localparam int PIX_W = 4;
  localparam int CFG_W = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [3:0] PIX_MAX = 4'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_MODE     = 2'd0,
    REG_SLICE_THRESHOLD = 2'd1,
    REG_IMAGE_WIDTH     = 2'd2,
    REG_IMAGE_HEIGHT    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_SHARPEN   = 3'd0,
    MODE_LAPLACIAN = 3'd1,
    MODE_HEDGE     = 3'd2,
    MODE_VEDGE     = 3'd3,
    MODE_AVERAGE   = 3'd4,
    MODE_SLICE     = 3'd5
  } filt_mode_t;

  localparam logic [2:0]       RST_FILTER_MODE     = 3'd0;
  localparam logic [3:0]       RST_SLICE_THRESHOLD = 4'd7;
  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH     = 10'd320;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT    = 10'd200;

  // Control that travels with a transaction from the read stage to the filter stage.
  typedef struct packed {
    logic first_col;  // column 0: finishes the last centre of an earlier row
    logic has_res;
    logic last;
    logic mask_top;
    logic mask_bot;
    logic mask_left;
  } s1_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/pixel_3x3_kernel_filter.sv @@
// Top level of the 3x3 pixel kernel filter: line memory, window and filter arithmetic.
// Depends on p3kf_pkg.
`default_nettype none

// Streaming 3x3 filter for 4-bit raster pixels. It takes one pixel per clock unless
// out_ready stalls a waiting result; a pixel reaches the result register
// via stage 1. A centre pixel's result leaves image_width+1 transactions after it
// went in, so each frame ends with image_width+1 padding transactions. Both line
// stores share one 8-bit wide memory of MAX_WIDTH entries, read at the current
// column on accept and written back as the pixel leaves stage 1; its single read and
// write port sets that rate. The memory has no reset and needs no clearing, as rows
// outside the image are masked to zero. The user must write configuration registers
// only while no transaction is in flight; the block does not enforce it.
module pixel_3x3_kernel_filter
  import p3kf_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PIX_W-1:0]     in_pixel_in,
  input  wire logic                 in_is_padding,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PIX_W-1:0]          out_pixel_out,
  output logic                      out_frame_last
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CWP = CW + 1;
  localparam int HW  = $clog2(MAX_HEIGHT + 3);
  localparam int CLW = (CWP > CFG_W) ? CWP : CFG_W;
  localparam int CLH = (HW > CFG_W) ? HW : CFG_W;

  // Configuration registers.
  logic [2:0]       filter_mode_r;
  logic [3:0]       slice_threshold_r;
  logic [CFG_W-1:0] image_width_r;
  logic [CFG_W-1:0] image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r     <= RST_FILTER_MODE;
      slice_threshold_r <= RST_SLICE_THRESHOLD;
      image_width_r     <= RST_IMAGE_WIDTH;
      image_height_r    <= RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FILTER_MODE:     filter_mode_r     <= cfg_wdata[2:0];
        REG_SLICE_THRESHOLD: slice_threshold_r <= cfg_wdata[3:0];
        REG_IMAGE_WIDTH:     image_width_r     <= cfg_wdata;
        REG_IMAGE_HEIGHT:    image_height_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to 3..MAX.
  logic [CLW-1:0] wx;
  logic [CLH-1:0] hx;
  logic [CWP-1:0] w_eff;
  logic [HW-1:0]  h_eff;
  logic [HW-1:0]  h_p1;

  always_comb begin
    wx = CLW'(image_width_r);
    hx = CLH'(image_height_r);
    if (wx < CLW'(3)) begin
      w_eff = CWP'(3);
    end else if (wx > CLW'(MAX_WIDTH)) begin
      w_eff = CWP'(MAX_WIDTH);
    end else begin
      w_eff = CWP'(wx);
    end
    if (hx < CLH'(3)) begin
      h_eff = HW'(3);
    end else if (hx > CLH'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(hx);
    end
    h_p1 = h_eff + HW'(1);
  end

  // Handshake and stage control.
  logic          s1_valid_r;
  s1_ctl_t       s1_ctl_r;
  logic [CW-1:0] s1_col_r;
  logic [3:0]    s1_pix_r;
  logic          out_valid_r;
  logic          s1_adv;
  logic          accept;

  assign s1_adv   = s1_valid_r && (!s1_ctl_r.has_res || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  // Position of the incoming transaction.
  logic [CW-1:0]  col_r, col_nxt;
  logic [HW-1:0]  row_r, row_nxt;
  logic           restart;
  logic [CW-1:0]  c0;
  logic [HW-1:0]  r0;
  logic [CWP-1:0] c0_p1;
  logic [3:0]     pix0;
  s1_ctl_t        ctl0;

  always_comb begin
    restart = (CWP'(col_r) >= w_eff) || (row_r > h_p1);
    c0      = restart ? '0 : col_r;
    r0      = restart ? '0 : row_r;
    c0_p1   = CWP'(c0) + CWP'(1);
    pix0    = (in_is_padding || (r0 >= h_eff)) ? 4'd0 : in_pixel_in;

    ctl0.first_col = (c0 == '0);
    if (ctl0.first_col) begin
      ctl0.has_res   = (r0 >= HW'(2));
      ctl0.last      = (r0 == h_p1);
      ctl0.mask_top  = (r0 == HW'(2));
      ctl0.mask_bot  = (r0 >= h_p1);
      ctl0.mask_left = 1'b0;
    end else begin
      ctl0.has_res   = (r0 >= HW'(1)) && (r0 <= h_eff);
      ctl0.last      = 1'b0;
      ctl0.mask_top  = (r0 == HW'(1));
      ctl0.mask_bot  = (r0 >= h_eff);
      ctl0.mask_left = (c0 == CW'(1));
    end

    if (ctl0.last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (c0_p1 >= w_eff) begin
      col_nxt = '0;
      row_nxt = r0 + HW'(1);
    end else begin
      col_nxt = c0_p1[CW-1:0];
      row_nxt = r0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_ctl_r   <= '0;
    end else begin
      if (accept) begin
        col_r    <= col_nxt;
        row_r    <= row_nxt;
        s1_ctl_r <= ctl0;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r <= c0;
      s1_pix_r <= pix0;
    end
  end

  // Line memory: upper row in [7:4], middle row in [3:0].
  logic [7:0] line_mem [MAX_WIDTH];
  logic [7:0] mem_q_r;
  logic [7:0] fwd_data_r;
  logic       fwd_hit_r;
  logic [7:0] rd_data;
  logic [7:0] wr_data;
  logic [3:0] top;
  logic [3:0] mid;

  assign rd_data = fwd_hit_r ? fwd_data_r : mem_q_r;
  assign top     = rd_data[7:4];
  assign mid     = rd_data[3:0];
  assign wr_data = {mid, s1_pix_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q_r <= line_mem[c0];
    end
    if (s1_adv) begin
      line_mem[s1_col_r] <= wr_data;
    end
  end

  // A read of the entry being written in the same cycle takes the new data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (accept) begin
      fwd_hit_r <= s1_adv && (c0 == s1_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data_r <= wr_data;
    end
  end

  // Window: index row * 3 + column, row 0 on top.
  logic [3:0] win_r   [9];
  logic [3:0] win_nxt [9];
  logic [3:0] shifted [9];
  logic [3:0] t       [9];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shifted[r*3]   = win_r[r*3+1];
      shifted[r*3+1] = win_r[r*3+2];
    end
    shifted[2] = s1_ctl_r.first_col ? 4'd0 : top;
    shifted[5] = s1_ctl_r.first_col ? 4'd0 : mid;
    shifted[8] = s1_ctl_r.first_col ? 4'd0 : s1_pix_r;

    for (int i = 0; i < 9; i++) begin
      win_nxt[i] = s1_ctl_r.first_col ? 4'd0 : shifted[i];
    end
    if (s1_ctl_r.first_col) begin
      win_nxt[2] = top;
      win_nxt[5] = mid;
      win_nxt[8] = s1_pix_r;
    end

    for (int i = 0; i < 9; i++) begin
      t[i] = shifted[i];
      if (s1_ctl_r.mask_top && (i < 3)) t[i] = 4'd0;
      if (s1_ctl_r.mask_bot && (i > 5)) t[i] = 4'd0;
      if (s1_ctl_r.mask_left && ((i % 3) == 0)) t[i] = 4'd0;
      if (s1_ctl_r.first_col && ((i % 3) == 2)) t[i] = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win_r[i] <= 4'd0;
    end else if (s1_adv) begin
      for (int i = 0; i < 9; i++) win_r[i] <= win_nxt[i];
    end
  end

  // Filter arithmetic on the masked window.
  function automatic logic [3:0] clamp15(input logic signed [9:0] z);
    logic [3:0] res;
    if (z < 0) begin
      res = 4'd0;
    end else if (z > 10'sd15) begin
      res = PIX_MAX;
    end else begin
      res = z[3:0];
    end
    return res;
  endfunction

  logic [6:0]        nsum;
  logic [5:0]        row_top, row_bot, col_left, col_right;
  logic signed [9:0] cen10, sharp_z, lap_z, hedge_z, vedge_z;
  logic [3:0]        res_pix;

  always_comb begin
    nsum = 7'(t[0]) + 7'(t[1]) + 7'(t[2]) + 7'(t[3])
         + 7'(t[5]) + 7'(t[6]) + 7'(t[7]) + 7'(t[8]);
    row_top   = 6'(t[0]) + 6'(t[1]) + 6'(t[2]);
    row_bot   = 6'(t[6]) + 6'(t[7]) + 6'(t[8]);
    col_left  = 6'(t[0]) + 6'(t[3]) + 6'(t[6]);
    col_right = 6'(t[2]) + 6'(t[5]) + 6'(t[8]);
    cen10     = $signed({6'd0, t[4]});
    lap_z     = (cen10 <<< 3) - $signed({3'd0, nsum});
    sharp_z   = lap_z + cen10;
    hedge_z   = $signed({4'd0, row_bot}) - $signed({4'd0, row_top});
    vedge_z   = $signed({4'd0, col_right}) - $signed({4'd0, col_left});
    case (filt_mode_t'(filter_mode_r))
      MODE_SHARPEN:   res_pix = clamp15(sharp_z);
      MODE_LAPLACIAN: res_pix = clamp15(lap_z);
      MODE_HEDGE:     res_pix = clamp15(hedge_z);
      MODE_VEDGE:     res_pix = clamp15(vedge_z);
      MODE_AVERAGE:   res_pix = nsum[6:3];
      MODE_SLICE:     res_pix = (t[4] > slice_threshold_r) ? PIX_MAX : 4'd0;
      default:        res_pix = 4'd0;
    endcase
  end

  // Result register.
  logic       out_valid_nxt;
  logic [3:0] out_pixel_r;
  logic       out_last_r;

  always_comb begin
    if (s1_adv && s1_ctl_r.has_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctl_r.has_res) begin
      out_pixel_r <= res_pix;
      out_last_r  <= s1_ctl_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pixel_r;
  assign out_frame_last = out_last_r;

  // Checks.
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ctl0.last |=> (col_r == '0) && (row_r == '0))
    else $error("position did not return to frame start after the last result");

  a_last_in_first_col: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_ctl_r.last |-> s1_ctl_r.first_col && s1_ctl_r.has_res)
    else $error("frame end flagged outside a first-column transaction");

  a_col_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && s1_adv |-> (c0 != s1_col_r) || s1_ctl_r.last)
    else $error("back-to-back line memory access to one column");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

@@ dv/tb_pixel_3x3_kernel_filter.sv @@
// Self-checking testbench for pixel_3x3_kernel_filter: raster pixel frames in,
// filtered pixels out, checked against a window-filter predictor kept in this file.
// Depends on p3kf_pkg and the pixel_3x3_kernel_filter RTL.
module tb_pixel_3x3_kernel_filter;
  import p3kf_pkg::*;

  localparam int MAX_W       = 512;
  localparam int MAX_H       = 512;
  localparam int MIN_DIM     = 3;
  localparam int IDLE_GAP    = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_ITEMS  = 500;
  localparam int BIG_ITEMS   = 580;
  localparam int DRAIN_LIMIT = 20000;
  localparam int MAX_SHOWN   = 10;
  localparam int TIMEOUT     = 2000000;

  // Mode codes with no defined filter; the block gives zero for them.
  localparam logic [2:0] MODE_RSVD_6 = 3'd6;
  localparam logic [2:0] MODE_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             pad;
  } pix_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } filt_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FILTER_MODE;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel_in = '0;
  logic                 in_is_padding = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_pixel_out;
  logic                 out_frame_last;
  logic                 rx_hold = 1'b0;

  int tx_idle_pct = 33;
  int rx_idle_pct = 63;
  int n_queued = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_frames = 0;
  int n_errors = 0;

  pix_item_t    source_q[$];
  filt_result_t filtered_q[$];

  // Predictor state: shadow registers, line stores, window and raster position.
  logic [2:0]       mode_cfg;
  logic [3:0]       thr_cfg;
  logic [CFG_W-1:0] width_cfg;
  logic [CFG_W-1:0] height_cfg;
  logic [3:0]       upper_line [MAX_W];
  logic [3:0]       middle_line [MAX_W];
  logic [3:0]       tap [9];
  int               col_pos;
  int               row_pos;

  pixel_3x3_kernel_filter #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_in   (in_pixel_in),
    .in_is_padding (in_is_padding),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_frame_last(out_frame_last)
  );

  always #2 clk = ~clk;

  function automatic int dim_limit(int v, int hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int sat_nibble(int v);
    if (v < 0) return 0;
    if (v > PIX_MAX) return PIX_MAX;
    return v;
  endfunction

  function automatic void shift_taps(logic [3:0] top_v, logic [3:0] mid_v, logic [3:0] bot_v);
    for (int r = 0; r < 3; r++) begin
      tap[r * 3]     = tap[r * 3 + 1];
      tap[r * 3 + 1] = tap[r * 3 + 2];
    end
    tap[2] = top_v;
    tap[5] = mid_v;
    tap[8] = bot_v;
  endfunction

  // Window index is row * 3 + column; taps that fall outside the frame read as zero.
  function automatic logic [3:0] centre_value(int cr, int cc, int w, int h);
    int t [9];
    int nsum;
    int z;
    foreach (t[i]) t[i] = tap[i];
    if (cr == 0) begin
      t[0] = 0; t[1] = 0; t[2] = 0;
    end
    if (cr + 1 >= h) begin
      t[6] = 0; t[7] = 0; t[8] = 0;
    end
    if (cc == 0) begin
      t[0] = 0; t[3] = 0; t[6] = 0;
    end
    if (cc + 1 >= w) begin
      t[2] = 0; t[5] = 0; t[8] = 0;
    end
    nsum = t[0] + t[1] + t[2] + t[3] + t[5] + t[6] + t[7] + t[8];
    case (mode_cfg)
      MODE_SHARPEN:   z = sat_nibble(9 * t[4] - nsum);
      MODE_LAPLACIAN: z = sat_nibble(8 * t[4] - nsum);
      MODE_HEDGE:     z = sat_nibble((t[6] + t[7] + t[8]) - (t[0] + t[1] + t[2]));
      MODE_VEDGE:     z = sat_nibble((t[2] + t[5] + t[8]) - (t[0] + t[3] + t[6]));
      MODE_AVERAGE:   z = nsum >> 3;
      MODE_SLICE:     z = (t[4] > thr_cfg) ? PIX_MAX : 0;
      default:        z = 0;
    endcase
    return z[3:0];
  endfunction

  // Advances the window by one accepted transaction and queues the filtered pixel it
  // completes, if any. A column-0 transaction finishes the right-edge centre of an
  // earlier row.
  task automatic window_filter_step(input logic [3:0] px_in, input logic pad_in);
    int           w;
    int           h;
    int           r;
    int           c;
    logic [3:0]   px;
    logic [3:0]   top_v;
    logic [3:0]   mid_v;
    bit           fin;
    filt_result_t res;
    w = dim_limit(width_cfg, MAX_W);
    h = dim_limit(height_cfg, MAX_H);
    if (col_pos >= w || row_pos > h + 1) begin
      col_pos = 0;
      row_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    px = (pad_in || r >= h) ? 4'd0 : px_in;
    top_v = upper_line[c];
    mid_v = middle_line[c];
    upper_line[c] = mid_v;
    middle_line[c] = px;
    fin = 1'b0;
    if (c == 0) begin
      shift_taps(4'd0, 4'd0, 4'd0);
      if (r >= 2) begin
        fin = (r == h + 1);
        res.pix = centre_value(r - 2, w - 1, w, h);
        res.last = fin;
        filtered_q.push_back(res);
      end
      foreach (tap[i]) tap[i] = 4'd0;
      tap[2] = top_v;
      tap[5] = mid_v;
      tap[8] = px;
    end else begin
      shift_taps(top_v, mid_v, px);
      if (r >= 1 && r <= h) begin
        res.pix = centre_value(r - 1, c - 1, w, h);
        res.last = 1'b0;
        filtered_q.push_back(res);
      end
    end
    if (fin) begin
      col_pos = 0;
      row_pos = 0;
    end else begin
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
      end
    end
  endtask

  function automatic void add_item(logic [3:0] p, logic pad);
    source_q.push_back('{pix: p, pad: pad});
    n_queued++;
  endfunction

  // One frame in raster order followed by its flush; cut > 0 stops it early.
  function automatic void queue_frame(int w, int h, int cut);
    bit extreme;
    int total;
    extreme = ($urandom_range(0, 3) == 0);
    total = w * h + w + 1;
    if (cut > 0 && cut < total) total = cut;
    for (int i = 0; i < total; i++) begin
      if (i < w * h)
        add_item(extreme ? ($urandom_range(0, 1) ? PIX_MAX : 4'd0) : 4'($urandom_range(0, 15)),
                 $urandom_range(0, 39) == 0);
      else
        add_item(4'($urandom_range(0, 15)), $urandom_range(0, 19) != 0);
    end
  endfunction

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_FILTER_MODE:     mode_cfg = val[2:0];
      REG_SLICE_THRESHOLD: thr_cfg = val[3:0];
      REG_IMAGE_WIDTH:     width_cfg = val;
      REG_IMAGE_HEIGHT:    height_cfg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Idle means every queued transaction accepted and every filtered pixel seen; the
  // extra cycles cover a transaction that is still in the pipe without a result.
  task automatic wait_idle();
    do @(negedge clk); while (source_q.size() != 0 || in_valid || filtered_q.size() != 0);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  always @(posedge clk) begin : driver
    pix_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        window_filter_step(in_pixel_in, in_is_padding);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (source_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          nxt = source_q.pop_front();
          in_valid <= 1'b1;
          in_pixel_in <= nxt.pix;
          in_is_padding <= nxt.pad;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    filt_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("unexpected filtered pixel %0d frame_last %0b", out_pixel_out,
                     out_frame_last);
        end else begin
          want = filtered_q.pop_front();
          n_checked++;
          if (out_frame_last === 1'b1) n_frames++;
          if (out_pixel_out !== want.pix || out_frame_last !== want.last) begin
            n_errors++;
            if (n_errors <= MAX_SHOWN)
              $display("mismatch at result %0d: expected pixel %0d last %0b, got pixel %0d last %0b",
                       n_checked, want.pix, want.last, out_pixel_out, out_frame_last);
          end
        end
      end
      out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Long receiver stall while the sender keeps offering, so the pipe fills and
  // in_ready has to drop. It starts once results are pending and plenty of
  // transactions are still queued.
  initial begin : rx_backpressure
    wait (n_accepted >= 300 && filtered_q.size() != 0 && source_q.size() >= 20);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [2:0] mode_seq [9];
    int         rnd_start;
    int         w_eff;
    int         h_eff;
    int         kind;
    int         n;
    mode_seq[0] = MODE_SHARPEN;
    mode_seq[1] = MODE_LAPLACIAN;
    mode_seq[2] = MODE_HEDGE;
    mode_seq[3] = MODE_VEDGE;
    mode_seq[4] = MODE_AVERAGE;
    mode_seq[5] = MODE_SLICE;
    mode_seq[6] = MODE_RSVD_6;
    mode_seq[7] = MODE_RSVD_7;
    mode_seq[8] = MODE_SLICE;
    mode_cfg = RST_FILTER_MODE;
    thr_cfg = RST_SLICE_THRESHOLD;
    width_cfg = RST_IMAGE_WIDTH;
    height_cfg = RST_IMAGE_HEIGHT;
    foreach (upper_line[i]) upper_line[i] = 4'd0;
    foreach (middle_line[i]) middle_line[i] = 4'd0;
    foreach (tap[i]) tap[i] = 4'd0;
    col_pos = 0;
    row_pos = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest frame, one mode per result. Includes a padding transaction inside the
    // frame and a real pixel during the flush.
    cfg_write(REG_IMAGE_WIDTH, 10'd3);
    cfg_write(REG_IMAGE_HEIGHT, 10'd3);
    cfg_write(REG_SLICE_THRESHOLD, 10'(PIX_MAX));
    cfg_write(REG_FILTER_MODE, 10'(MODE_SHARPEN));
    for (int i = 0; i < 13; i++) begin
      if (i >= 4) begin
        wait_idle();
        if (i == 12) cfg_write(REG_SLICE_THRESHOLD, 10'd0);
        cfg_write(REG_FILTER_MODE, 10'(mode_seq[i - 4]));
      end
      @(negedge clk);
      add_item((i % 3 == 1) ? 4'd0 : PIX_MAX, (i == 5) || (i >= 9 && i != 10));
    end

    // Width shrinks under the current column, which restarts the frame.
    wait_idle();
    cfg_write(REG_IMAGE_WIDTH, 10'd4);
    cfg_write(REG_IMAGE_HEIGHT, 10'd4);
    @(negedge clk);
    for (int i = 0; i < 3; i++) add_item(4'($urandom_range(0, 15)), 1'b0);
    wait_idle();
    cfg_write(REG_IMAGE_WIDTH, 10'd3);
    cfg_write(REG_IMAGE_HEIGHT, 10'd3);
    @(negedge clk);
    queue_frame(3, 3, 0);

    // Out-of-range geometry clamps to the maximum; one full row plus part of a second.
    wait_idle();
    cfg_write(REG_IMAGE_WIDTH, 10'd1023);
    cfg_write(REG_IMAGE_HEIGHT, 10'd1023);
    cfg_write(REG_FILTER_MODE, 10'($urandom_range(MODE_SHARPEN, MODE_SLICE)));
    @(negedge clk);
    for (int i = 0; i < BIG_ITEMS; i++)
      add_item(4'($urandom_range(0, 15)), $urandom_range(0, 49) == 0);
    wait_idle();
    cfg_write(REG_IMAGE_WIDTH, 10'd3);
    cfg_write(REG_IMAGE_HEIGHT, 10'd3);

    rnd_start = n_queued;
    while (n_queued - rnd_start < RAND_ITEMS) begin
      wait_idle();
      if (n_queued - rnd_start < RAND_ITEMS / 3) begin
        tx_idle_pct = 33;
        rx_idle_pct = 63;
      end else if (n_queued - rnd_start < 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 63;
        rx_idle_pct = 33;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      cfg_write(REG_FILTER_MODE, 10'($urandom_range(MODE_SHARPEN, MODE_RSVD_7)));
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 3))
          0:       cfg_write(REG_SLICE_THRESHOLD, 10'd0);
          1:       cfg_write(REG_SLICE_THRESHOLD, 10'(PIX_MAX));
          default: cfg_write(REG_SLICE_THRESHOLD, 10'($urandom_range(0, 15)));
        endcase
      end
      if ($urandom_range(0, 2) == 0)
        cfg_write(REG_IMAGE_WIDTH, ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 2))
                                                               : 10'($urandom_range(3, 10)));
      if ($urandom_range(0, 2) == 0)
        cfg_write(REG_IMAGE_HEIGHT, ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 2))
                                                                : 10'($urandom_range(3, 8)));
      w_eff = dim_limit(width_cfg, MAX_W);
      h_eff = dim_limit(height_cfg, MAX_H);
      kind = $urandom_range(0, 19);
      @(negedge clk);
      if (kind < 15) begin
        queue_frame(w_eff, h_eff, 0);
      end else if (kind < 18) begin
        queue_frame(w_eff, h_eff, $urandom_range(1, w_eff * h_eff + w_eff));
      end else begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
          add_item(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end
    end

    do @(negedge clk); while (source_q.size() != 0 || in_valid);
    n = 0;
    while (filtered_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (IDLE_GAP) @(posedge clk);
    if (filtered_q.size() != 0) begin
      n_errors += filtered_q.size();
      $display("%0d filtered pixels never arrived", filtered_q.size());
    end
    $display("Checked %0d filtered pixels and %0d frame ends from %0d input transactions,",
             n_checked, n_frames, n_accepted);
    $display("across all mode codes, frame sizes 3 to 512, padding and stalls on both sides.");
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
